// ----- design/slx_pkg.sv -----
// Shared types, constants and helpers for the source code lexer.
`timescale 1ns / 1ps
package slx_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF     = 512;
  localparam int unsigned MAX_COMMENT_DEPTH_DEF = 255;

  localparam int unsigned IQ_DEPTH = 2;
  localparam int unsigned OQ_DEPTH = 4;

  localparam int unsigned VAL_W  = 63;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned LINE_W = 20;
  localparam int unsigned COL_W  = 16;

  localparam logic [VAL_W-1:0]  VALUE_MAX = {VAL_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_MAX  = {LINE_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_MAX   = {COL_W{1'b1}};

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    CC_SPACE,
    CC_ALPHA,
    CC_DIGIT,
    CC_SLASH,
    CC_MINUS,
    CC_OTHER
  } chr_class_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SLASH,
    PH_LINE,
    PH_BLOCK,
    PH_BSTAR,
    PH_BSLASH,
    PH_IDENT,
    PH_INT,
    PH_FRAC,
    PH_MINUS
  } lex_phase_t;

  typedef enum logic [2:0] {
    TK_EOF,
    TK_IDENT,
    TK_TYPE,
    TK_INT,
    TK_DEC,
    TK_ARROW,
    TK_CHAR,
    TK_UNKNOWN
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    chr_class_t cls;
  } item_t;

  typedef struct packed {
    tok_kind_t         kind;
    logic [7:0]        ch;
    logic [VAL_W-1:0]  val;
    logic [LEN_W-1:0]  frac;
    logic              sat;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic              last;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    case (idx)
      2'd0:    kw_char = 8'h74;
      2'd1:    kw_char = 8'h79;
      2'd2:    kw_char = 8'h70;
      default: kw_char = 8'h65;
    endcase
  endfunction

  function automatic chr_class_t classify(input logic [7:0] c);
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) classify = CC_SPACE;
    else if (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) classify = CC_ALPHA;
    else if (c inside {[8'h30:8'h39]}) classify = CC_DIGIT;
    else if (c == CH_SLASH) classify = CC_SLASH;
    else if (c == CH_MINUS) classify = CC_MINUS;
    else classify = CC_OTHER;
  endfunction

  function automatic tok_t mk_tok(input tok_kind_t kind, input logic [7:0] ch,
                                  input logic [VAL_W-1:0] val, input logic [LEN_W-1:0] frac,
                                  input logic sat, input logic [LEN_W-1:0] len,
                                  input logic [LINE_W-1:0] line, input logic [COL_W-1:0] col);
    tok_t t;
    t.kind = kind;
    t.ch   = ch;
    t.val  = val;
    t.frac = frac;
    t.sat  = sat;
    t.len  = len;
    t.line = line;
    t.col  = col;
    t.last = 1'b0;
    mk_tok = t;
  endfunction

endpackage

// ----- design/source_code_lexer.sv -----
// Top level of the source code lexer: front classifier, lexer core and result queue.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: char_code; tuser: end_of_input
//  out_    | out | out_tvalid/tready  | tdata: token fields; tuser: token_kind; tlast
//
// One input beat per cycle sustained while results average at most one beat per input beat.
// A beat yields zero, one or two result beats, drained from a 4-entry queue at one per cycle while out_tready is high.
// An input beat is registered in the input queue, and its result beats in the result queue, before they reach out_.
// rst_n is synchronous, active low; positions restart at line 1, column 1.
// A stall on the result side backs up into the 2-entry input queue and then in_tready.
`timescale 1ns / 1ps
module source_code_lexer #(
  parameter int unsigned MAX_TOKEN_LEN     = slx_pkg::MAX_TOKEN_LEN_DEF,
  parameter int unsigned MAX_COMMENT_DEPTH = slx_pkg::MAX_COMMENT_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_code
  input  logic         in_tuser,   // [0] end_of_input
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // token_char, number_value, fraction_digits,
                                   // value_saturated, token_length, start_line, start_column
  output logic [2:0]   out_tuser,  // [2:0] token_kind
  output logic         out_tlast   // last_of_run
);
  import slx_pkg::*;

  item_t iq_item;
  logic  iq_valid;
  logic  take;
  logic  room;
  push_t push;
  tok_t  head;

  slx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .iq_item   (iq_item),
    .iq_valid  (iq_valid),
    .iq_pop    (take)
  );

  slx_core #(
    .MAX_TOKEN_LEN     (MAX_TOKEN_LEN),
    .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (iq_item),
    .item_valid (iq_valid),
    .room       (room),
    .take       (take),
    .push       (push)
  );

  slx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (head)
  );

  assign out_tdata = {head.col, head.line, head.len, head.sat, head.frac, head.val, head.ch};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// ----- design/slx_front.sv -----
// Front end: takes input beats, classifies each byte and queues it for the lexer core.
`timescale 1ns / 1ps
module slx_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tuser,
  output slx_pkg::item_t iq_item,
  output logic          iq_valid,
  input  logic          iq_pop
);
  import slx_pkg::*;

  localparam int unsigned PTR_W = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(IQ_DEPTH + 1);

  item_t             mem [IQ_DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push;
  logic              pop;
  item_t             new_item;

  assign in_tready = (cnt_r != CNT_W'(IQ_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign iq_valid  = (cnt_r != '0);
  assign pop       = iq_pop && iq_valid;
  assign iq_item   = mem[rd_r];

  always_comb begin
    new_item.ch  = in_tdata;
    new_item.eoi = in_tuser;
    new_item.cls = classify(in_tdata);
    wr_nxt  = push ? PTR_W'(wr_r + 1'b1) : wr_r;
    rd_nxt  = pop ? PTR_W'(rd_r + 1'b1) : rd_r;
    cnt_nxt = CNT_W'(cnt_r + CNT_W'(push) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- design/slx_core.sv -----
// Lexer core: per-byte state update, emits up to two tokens per taken item.
`timescale 1ns / 1ps
module slx_core #(
  parameter int unsigned MAX_TOKEN_LEN     = slx_pkg::MAX_TOKEN_LEN_DEF,
  parameter int unsigned MAX_COMMENT_DEPTH = slx_pkg::MAX_COMMENT_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  slx_pkg::item_t item,
  input  logic           item_valid,
  input  logic           room,
  output logic           take,
  output slx_pkg::push_t push
);
  import slx_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned DEP_W = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [CNT_W-1:0] LIMIT     = CNT_W'(MAX_TOKEN_LEN);
  localparam logic [DEP_W-1:0] DEPTH_MAX = DEP_W'(MAX_COMMENT_DEPTH);

  lex_phase_t        phase_r, phase_nxt;
  logic [DEP_W-1:0]  depth_r, depth_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  frac_r, frac_nxt;
  logic              ovf_r, ovf_nxt;
  logic [2:0]        kwp_r, kwp_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] tline_r, tline_nxt;
  logic [COL_W-1:0]  tcol_r, tcol_nxt;

  logic [7:0]        c;
  chr_class_t        cls;
  logic [COL_W-1:0]  col_inc;
  logic [CNT_W-1:0]  cnt_inc;
  logic [3:0]        dig;
  logic [VAL_W+3:0]  acc_wide;
  logic [VAL_W-1:0]  acc_step;
  logic              acc_ovf;
  logic              kw_hit;
  tok_kind_t         id_kind;
  logic              use_sc;
  logic              e0_v, e1_v;
  tok_t              e0, e1;
  tok_t              blank;

  assign take = item_valid && room;
  assign c    = item.ch;
  assign cls  = item.cls;
  assign dig  = item.ch[3:0];

  always_comb begin
    col_inc  = (col_r == COL_MAX) ? col_r : COL_W'(col_r + 1'b1);
    cnt_inc  = CNT_W'(cnt_r + 1'b1);
    acc_wide = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (VAL_W + 4)'(dig);
    acc_ovf  = (acc_wide > (VAL_W + 4)'(VALUE_MAX));
    acc_step = acc_ovf ? VALUE_MAX : acc_wide[VAL_W-1:0];
    kw_hit   = (CNT_W'(kwp_r) == cnt_r) && (cnt_r < CNT_W'(4)) && (c == kw_char(cnt_r[1:0]));
    id_kind  = (kwp_r == 3'd4 && cnt_r == CNT_W'(4)) ? TK_TYPE : TK_IDENT;
    blank    = mk_tok(TK_EOF, 8'd0, '0, '0, 1'b0, '0, tline_r, tcol_r);
  end

  always_comb begin
    phase_nxt = phase_r;
    depth_nxt = depth_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    frac_nxt  = frac_r;
    ovf_nxt   = ovf_r;
    kwp_nxt   = kwp_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    e0_v      = 1'b0;
    e1_v      = 1'b0;
    e0        = blank;
    e1        = blank;
    use_sc    = 1'b0;
    if (take) begin
      if (item.eoi) begin
        case (phase_r)
          PH_SLASH: begin
            e0_v = 1'b1;
            e0   = mk_tok(TK_CHAR, CH_SLASH, '0, '0, 1'b0, LEN_W'(1), tline_r, tcol_r);
          end
          PH_BLOCK, PH_BSTAR, PH_BSLASH: begin
            e0_v = 1'b1;
            e0   = mk_tok(TK_UNKNOWN, 8'd0, '0, '0, 1'b0, '0, tline_r, tcol_r);
          end
          PH_IDENT: begin
            e0_v = 1'b1;
            e0   = mk_tok(id_kind, 8'd0, '0, '0, 1'b0, LEN_W'(cnt_r), tline_r, tcol_r);
          end
          PH_INT: begin
            e0_v = 1'b1;
            e0   = mk_tok(TK_INT, 8'd0, acc_r, '0, ovf_r, LEN_W'(cnt_r), tline_r, tcol_r);
          end
          PH_FRAC: begin
            e0_v = 1'b1;
            e0   = mk_tok(TK_DEC, 8'd0, acc_r, LEN_W'(frac_r), ovf_r, LEN_W'(cnt_r),
                          tline_r, tcol_r);
          end
          PH_MINUS: begin
            e0_v = 1'b1;
            e0   = mk_tok(TK_CHAR, CH_MINUS, '0, '0, 1'b0, LEN_W'(1), tline_r, tcol_r);
          end
          default: begin
          end
        endcase
        e1_v      = 1'b1;
        e1        = mk_tok(TK_EOF, 8'd0, '0, '0, 1'b0, '0, line_r, col_inc);
        phase_nxt = PH_IDLE;
        depth_nxt = '0;
      end else begin
        if (c == CH_LF) begin
          col_nxt  = '0;
          line_nxt = (line_r == LINE_MAX) ? line_r : LINE_W'(line_r + 1'b1);
        end else begin
          col_nxt = col_inc;
        end
        case (phase_r)
          PH_SLASH: begin
            if (c == CH_SLASH) begin
              phase_nxt = PH_LINE;
            end else if (c == CH_STAR) begin
              phase_nxt = PH_BLOCK;
              depth_nxt = DEP_W'(1);
            end else begin
              e0_v   = 1'b1;
              e0     = mk_tok(TK_CHAR, CH_SLASH, '0, '0, 1'b0, LEN_W'(1), tline_r, tcol_r);
              use_sc = 1'b1;
            end
          end
          PH_LINE: begin
            if (c == CH_LF || c == CH_CR) phase_nxt = PH_IDLE;
          end
          PH_BLOCK: begin
            if (c == CH_STAR) phase_nxt = PH_BSTAR;
            else if (c == CH_SLASH) phase_nxt = PH_BSLASH;
          end
          PH_BSTAR: begin
            if (c == CH_SLASH) begin
              if (depth_r <= DEP_W'(1)) begin
                depth_nxt = '0;
                phase_nxt = PH_IDLE;
              end else begin
                depth_nxt = DEP_W'(depth_r - 1'b1);
                phase_nxt = PH_BLOCK;
              end
            end else if (c != CH_STAR) begin
              phase_nxt = PH_BLOCK;
            end
          end
          PH_BSLASH: begin
            if (c == CH_STAR) begin
              if (depth_r < DEPTH_MAX) depth_nxt = DEP_W'(depth_r + 1'b1);
              phase_nxt = PH_BLOCK;
            end else if (c != CH_SLASH) begin
              phase_nxt = PH_BLOCK;
            end
          end
          PH_IDENT: begin
            if (cls == CC_ALPHA || cls == CC_DIGIT || c == CH_USCORE) begin
              kwp_nxt = kw_hit ? 3'(cnt_inc) : 3'd7;
              cnt_nxt = cnt_inc;
              if (cnt_inc >= LIMIT) begin
                e0_v      = 1'b1;
                e0        = mk_tok(TK_UNKNOWN, 8'd0, '0, '0, 1'b0, LEN_W'(cnt_inc),
                                   tline_r, tcol_r);
                phase_nxt = PH_IDLE;
              end
            end else begin
              e0_v   = 1'b1;
              e0     = mk_tok(id_kind, 8'd0, '0, '0, 1'b0, LEN_W'(cnt_r), tline_r, tcol_r);
              use_sc = 1'b1;
            end
          end
          PH_INT, PH_FRAC: begin
            if (cls == CC_DIGIT) begin
              acc_nxt = acc_step;
              if (acc_ovf) ovf_nxt = 1'b1;
              if (phase_r == PH_FRAC) frac_nxt = CNT_W'(frac_r + 1'b1);
              cnt_nxt = cnt_inc;
              if (cnt_inc >= LIMIT) begin
                e0_v      = 1'b1;
                e0        = mk_tok(TK_UNKNOWN, 8'd0, '0, '0, 1'b0, LEN_W'(cnt_inc),
                                   tline_r, tcol_r);
                phase_nxt = PH_IDLE;
              end
            end else if (phase_r == PH_INT && c == CH_DOT) begin
              cnt_nxt = cnt_inc;
              if (cnt_inc >= LIMIT) begin
                e0_v      = 1'b1;
                e0        = mk_tok(TK_UNKNOWN, 8'd0, '0, '0, 1'b0, LEN_W'(cnt_inc),
                                   tline_r, tcol_r);
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_FRAC;
              end
            end else begin
              e0_v = 1'b1;
              if (phase_r == PH_INT) begin
                e0 = mk_tok(TK_INT, 8'd0, acc_r, '0, ovf_r, LEN_W'(cnt_r), tline_r, tcol_r);
              end else begin
                e0 = mk_tok(TK_DEC, 8'd0, acc_r, LEN_W'(frac_r), ovf_r, LEN_W'(cnt_r),
                            tline_r, tcol_r);
              end
              use_sc = 1'b1;
            end
          end
          PH_MINUS: begin
            e0_v = 1'b1;
            if (c == CH_GT) begin
              e0        = mk_tok(TK_ARROW, 8'd0, '0, '0, 1'b0, LEN_W'(2), tline_r, tcol_r);
              phase_nxt = PH_IDLE;
            end else begin
              e0     = mk_tok(TK_CHAR, CH_MINUS, '0, '0, 1'b0, LEN_W'(1), tline_r, tcol_r);
              use_sc = 1'b1;
            end
          end
          default: begin
            use_sc = 1'b1;
          end
        endcase

        // fresh token start on this byte
        if (use_sc) begin
          phase_nxt = PH_IDLE;
          if (cls != CC_SPACE) begin
            tline_nxt = line_r;
            tcol_nxt  = col_inc;
            cnt_nxt   = '0;
            case (cls)
              CC_SLASH: phase_nxt = PH_SLASH;
              CC_MINUS: phase_nxt = PH_MINUS;
              CC_ALPHA: begin
                phase_nxt = PH_IDENT;
                kwp_nxt   = (c == kw_char(2'd0)) ? 3'd1 : 3'd7;
                cnt_nxt   = CNT_W'(1);
              end
              CC_DIGIT: begin
                phase_nxt = PH_INT;
                acc_nxt   = VAL_W'(dig);
                frac_nxt  = '0;
                ovf_nxt   = 1'b0;
                cnt_nxt   = CNT_W'(1);
              end
              default: begin
                e1_v = 1'b1;
                e1   = mk_tok(TK_CHAR, c, '0, '0, 1'b0, LEN_W'(1), line_r, col_inc);
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    push.n  = 2'(e0_v) + 2'(e1_v);
    push.t0 = e0_v ? e0 : e1;
    push.t1 = e1;
    push.t0.last = !(e0_v && e1_v);
    push.t1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      depth_r <= '0;
      cnt_r   <= '0;
      acc_r   <= '0;
      frac_r  <= '0;
      ovf_r   <= 1'b0;
      kwp_r   <= '0;
      line_r  <= LINE_W'(1);
      col_r   <= '0;
      tline_r <= LINE_W'(1);
      tcol_r  <= COL_W'(1);
    end else begin
      phase_r <= phase_nxt;
      depth_r <= depth_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      frac_r  <= frac_nxt;
      ovf_r   <= ovf_nxt;
      kwp_r   <= kwp_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
    end
  end

  a_depth_in_comment: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BLOCK || phase_r == PH_BSTAR || phase_r == PH_BSLASH) |-> depth_r != '0)
    else $error("comment phase with zero nesting depth");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != '0) && (tline_r != '0) && (tcol_r != '0))
    else $error("line or token position dropped to zero");

  a_no_take_without_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> take)
    else $error("token produced with no item taken");

endmodule

// ----- design/slx_outq.sv -----
// Result queue: takes up to two tokens per cycle, hands out one beat per cycle while out_ready is high.
`timescale 1ns / 1ps
module slx_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  slx_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output slx_pkg::tok_t  out_tok
);
  import slx_pkg::*;

  localparam int unsigned PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(OQ_DEPTH + 1);

  tok_t             q [OQ_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [PTR_W-1:0] wr_p1;

  assign room      = (cnt_r <= CNT_W'(OQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_tok   = q[rd_r];
  assign pop       = out_valid && out_ready;
  assign wr_p1     = PTR_W'(wr_r + 1'b1);

  always_comb begin
    wr_nxt  = PTR_W'(wr_r + PTR_W'(push.n));
    rd_nxt  = pop ? PTR_W'(rd_r + 1'b1) : rd_r;
    cnt_nxt = CNT_W'(cnt_r + CNT_W'(push.n) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q[wr_r] <= push.t0;
    end
    if (push.n == 2'd2) begin
      q[wr_p1] <= push.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (CNT_W'(cnt_r + CNT_W'(push.n)) <= CNT_W'(OQ_DEPTH)))
    else $error("result queue overflow");

  a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tok.last) |-> (cnt_r >= CNT_W'(2)))
    else $error("first token of a pair without its partner queued");

endmodule
